// ===== sv/egp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egp_pkg
// Shared types, constants and the fixed 2^-f interpolation table.
// ----------------------------------------------------------------------------
package egp_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] FLUSH_R2  = 64'd24 << 32;

    localparam int SAT_MAX = 2147483647;

    typedef enum logic [2:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_COEF_YX  = 3'd2,
        REG_COEF_YY  = 3'd3,
        REG_OFFSET_U = 3'd4,
        REG_OFFSET_V = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] coef_xx;
        logic signed [31:0] coef_xy;
        logic signed [31:0] coef_yx;
        logic signed [31:0] coef_yy;
        logic signed [31:0] offset_u;
        logic signed [31:0] offset_v;
    } cfg_t;

    // Transformed coordinate pair that rides along to the output
    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               sat;
    } grid_t;

    typedef logic [30:0] exp_tab_t [0:EXP_TABLE_DEPTH];

    // 2^-f in Q.30 for f = i/DEPTH, from an alternating exp series
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            x    = (64'(i) * LN2_Q30 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
            sum  = longint'(ONE_Q30);
            term = ONE_Q30;
            for (int n = 1; n <= 24; n++) begin
                if (term != 64'd0) begin
                    term = ((term * x + (64'd1 << 29)) >> 30) / 64'(n);
                    if ((n % 2) == 1) sum = sum - longint'(term);
                    else              sum = sum + longint'(term);
                end
            end
            if (sum < 0) sum = 0;
            t[i] = sum[30:0];
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== sv/egp_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egp_xform
// Two stages: coefficient products, then rounded sum, offset and saturation.
// ----------------------------------------------------------------------------
module egp_xform (
    input  logic                            aclk,
    input  logic [1:0]                      adv,
    input  egp_pkg::cfg_t                   cfg,
    input  logic signed [15:0]              pixel_x,
    input  logic signed [15:0]              pixel_y,
    output egp_pkg::grid_t                  grid
);
    import egp_pkg::*;

    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [31+COORD_WIDTH:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg;
    grid_t grid_reg, grid_next;

    assign x = pixel_x[COORD_WIDTH-1:0];
    assign y = pixel_y[COORD_WIDTH-1:0];

    function automatic logic signed [33+COORD_WIDTH:0] round_off(
        input logic signed [31+COORD_WIDTH:0] p0,
        input logic signed [31+COORD_WIDTH:0] p1,
        input logic signed [31:0]             off
    );
        logic signed [32+COORD_WIDTH:0] s;
        s = (33+COORD_WIDTH)'(p0) + (33+COORD_WIDTH)'(p1) + (33+COORD_WIDTH)'(128);
        return (34+COORD_WIDTH)'(s >>> 8) + (34+COORD_WIDTH)'(off);
    endfunction

    function automatic logic [32:0] clip(input logic signed [33+COORD_WIDTH:0] q);
        logic signed [33+COORD_WIDTH:0] hi;
        logic signed [33+COORD_WIDTH:0] lo;
        hi = (34+COORD_WIDTH)'(SAT_MAX);
        lo = -hi - (34+COORD_WIDTH)'(1);
        if (q > hi)      return {1'b1, hi[31:0]};
        else if (q < lo) return {1'b1, lo[31:0]};
        else             return {1'b0, q[31:0]};
    endfunction

    logic [32:0] cu, cv;

    always_comb begin
        cu = clip(round_off(pxx_reg, pxy_reg, cfg.offset_u));
        cv = clip(round_off(pyx_reg, pyy_reg, cfg.offset_v));
        grid_next.u   = cu[31:0];
        grid_next.v   = cv[31:0];
        grid_next.sat = cu[32] | cv[32];
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            pxx_reg <= cfg.coef_xx * x;
            pxy_reg <= cfg.coef_xy * y;
            pyx_reg <= cfg.coef_yx * x;
            pyy_reg <= cfg.coef_yy * y;
        end
        if (adv[1]) begin
            grid_reg <= grid_next;
        end
    end

    assign grid = grid_reg;

endmodule

// ===== sv/egp_radius.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egp_radius
// Three stages: squares, radius sum with flush test, scale to log2 domain.
// ----------------------------------------------------------------------------
module egp_radius (
    input  logic           aclk,
    input  logic [2:0]     adv,
    input  egp_pkg::grid_t grid_in,
    output egp_pkg::grid_t grid_out,
    output logic [28:0]    b_out,
    output logic           flush_out
);
    import egp_pkg::*;

    grid_t g3_reg, g4_reg, g5_reg;
    logic [63:0] squ_reg, sqv_reg;
    logic [63:0] r2;
    logic [27:0] a_reg;
    logic        fl4_reg, fl5_reg;
    logic [28:0] b_reg;
    logic [58:0] prod;

    assign r2   = squ_reg + sqv_reg;
    assign prod = 59'(a_reg) * 59'(LOG2E_Q30) + (59'd1 << 29);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            g3_reg  <= grid_in;
            squ_reg <= 64'(grid_in.u) * 64'(grid_in.u);
            sqv_reg <= 64'(grid_in.v) * 64'(grid_in.v);
        end
        if (adv[1]) begin
            g4_reg  <= g3_reg;
            fl4_reg <= r2 >= FLUSH_R2;
            a_reg   <= r2[36:9];
        end
        if (adv[2]) begin
            g5_reg  <= g4_reg;
            fl5_reg <= fl4_reg;
            b_reg   <= prod[58:30];
        end
    end

    assign grid_out  = g5_reg;
    assign b_out     = b_reg;
    assign flush_out = fl5_reg;

endmodule

// ===== sv/egp_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egp_exp
// Three stages: table lookup, interpolation, final power-of-two shift.
// ----------------------------------------------------------------------------
module egp_exp (
    input  logic           aclk,
    input  logic [2:0]     adv,
    input  egp_pkg::grid_t grid_in,
    input  logic [28:0]    b_in,
    input  logic           flush_in,
    output egp_pkg::grid_t grid_out,
    output logic [16:0]    model_out
);
    import egp_pkg::*;

    logic [EXP_IDX_BITS-1:0] idx;
    logic [EXP_IDX_BITS:0]   idx1;
    logic [23:0]             w;
    grid_t g6_reg, g7_reg, g8_reg;
    logic [30:0] t0_reg, dif_reg, val_reg;
    logic [23:0] w_reg;
    logic [4:0]  k6_reg, k7_reg;
    logic        fl6_reg, fl7_reg;
    logic [16:0] model_reg;
    logic [54:0] corr;
    logic [31:0] rnd;
    logic [5:0]  s;

    assign idx  = b_in[23 -: EXP_IDX_BITS];
    assign idx1 = (EXP_IDX_BITS+1)'(idx) + (EXP_IDX_BITS+1)'(1);
    assign w    = {b_in[23-EXP_IDX_BITS:0], {EXP_IDX_BITS{1'b0}}};
    assign corr = (55'(dif_reg) * 55'(w_reg) + (55'd1 << 23)) >> 24;
    assign s    = 6'd14 + 6'(k7_reg);
    assign rnd  = (32'(val_reg) + (32'd1 << (s - 6'd1))) >> s;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            g6_reg  <= grid_in;
            fl6_reg <= flush_in;
            k6_reg  <= b_in[28:24];
            w_reg   <= w;
            t0_reg  <= EXP_TAB[idx];
            dif_reg <= EXP_TAB[idx] - EXP_TAB[idx1];
        end
        if (adv[1]) begin
            g7_reg  <= g6_reg;
            fl7_reg <= fl6_reg;
            k7_reg  <= k6_reg;
            val_reg <= t0_reg - corr[30:0];
        end
        if (adv[2]) begin
            g8_reg    <= g7_reg;
            model_reg <= fl7_reg ? 17'd0 : rnd[16:0];
        end
    end

    assign grid_out  = g8_reg;
    assign model_out = model_reg;

endmodule

// ===== sv/elliptical_gaussian_pixel_eval_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elliptical_gaussian_pixel_eval_top
// Affine grid transform of a pixel coordinate and Gaussian profile value.
// ----------------------------------------------------------------------------
// Usage:
//   Send one pixel per transaction on the s_ channel: s_tdata holds pixel_x
//   in [15:0] and pixel_y in [31:16]. Each pixel yields one transaction on the
//   m_ channel with grid_u, grid_v (Q16.16, saturated) and model_value
//   (Q1.16); m_tuser flags a clipped coordinate.
//   A pixel reaches m_tvalid through eight register stages, the first one
//   loaded at the accepting edge. Throughput is one pixel per cycle while
//   m_tready does not stall, set by the eight-stage pipeline (two transform
//   stages, three radius, three exponential stages), each stage one multiplier deep.
//   Each stage has its own valid bit and advances when it is empty or the
//   stage after it moves, so bubbles close up and a stalled m_tready holds
//   the output while upstream stages keep filling; s_tready drops only once
//   all eight stages are full.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect on the
//   next edge; write only while the pipeline is empty. Indexes 6 and 7 are
//   ignored.
//   Synchronous reset empties the pipeline and loads the identity transform
//   with zero offsets. The exponential table is a constant, no fill needed.
// ----------------------------------------------------------------------------
module elliptical_gaussian_pixel_eval_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] pixel_x, [31:16] pixel_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [31:0] grid_u, [63:32] grid_v, [80:64] model_value
    output logic [0:0]  m_tuser,   // [0] saturated
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import egp_pkg::*;

    localparam int STAGES = 8;

    cfg_t               cfg_reg;
    logic [STAGES:1]    valid_reg;
    logic [STAGES+1:1]  adv;
    grid_t              g2, g5, g8;
    logic [28:0]        b5;
    logic               fl5;
    logic [16:0]        model;

    // Stage i loads when it is empty or its content moves on
    always_comb begin
        adv[STAGES+1] = m_tready;
        for (int i = STAGES; i >= 1; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int i = 2; i <= STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_xx  <= 32'sd16777216;
            cfg_reg.coef_xy  <= '0;
            cfg_reg.coef_yx  <= '0;
            cfg_reg.coef_yy  <= 32'sd16777216;
            cfg_reg.offset_u <= '0;
            cfg_reg.offset_v <= '0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_COEF_XX:  cfg_reg.coef_xx  <= cfg_wdata;
                REG_COEF_XY:  cfg_reg.coef_xy  <= cfg_wdata;
                REG_COEF_YX:  cfg_reg.coef_yx  <= cfg_wdata;
                REG_COEF_YY:  cfg_reg.coef_yy  <= cfg_wdata;
                REG_OFFSET_U: cfg_reg.offset_u <= cfg_wdata;
                REG_OFFSET_V: cfg_reg.offset_v <= cfg_wdata;
                default: ;    // drop writes to unused indexes
            endcase
        end
    end

    egp_xform u_xform (
        .aclk    (aclk),
        .adv     (adv[2:1]),
        .cfg     (cfg_reg),
        .pixel_x (s_tdata[15:0]),
        .pixel_y (s_tdata[31:16]),
        .grid    (g2)
    );

    egp_radius u_radius (
        .aclk      (aclk),
        .adv       (adv[5:3]),
        .grid_in   (g2),
        .grid_out  (g5),
        .b_out     (b5),
        .flush_out (fl5)
    );

    egp_exp u_exp (
        .aclk      (aclk),
        .adv       (adv[8:6]),
        .grid_in   (g5),
        .b_in      (b5),
        .flush_in  (fl5),
        .grid_out  (g8),
        .model_out (model)
    );

    assign m_tvalid = valid_reg[STAGES];
    assign m_tdata  = {7'd0, model, g8.v, g8.u};
    assign m_tuser  = g8.sat;

`ifndef ASSERT_OFF
    // An empty output stage must never back-pressure the input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    // The Gaussian value never exceeds one
    a_model_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[80:64] <= 17'd65536))
        else $error("model_value above 1.0");

    // An accepted pixel with an empty pipe is valid at the output once it
    // has passed through every pipeline stage
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && valid_reg == '0 && m_tready) |=> ##7 m_tvalid)
        else $error("result missing after pipeline latency");
`endif

endmodule
